### sv/svm_pkg.sv
// Shared types and constants of the sample voice mixer.
// Depends on nothing; every file but the two channel interfaces imports it.
package svm_pkg;

   localparam int VOICES       = 64;
   localparam int VOICE_W      = $clog2(VOICES);
   localparam int ADDR_W       = 16;
   localparam int SAMPLE_WORDS = 1 << ADDR_W;
   localparam int SMP_W        = 16;
   localparam int LEN_W        = 17;
   localparam int RATE_W       = 24;
   localparam int GAIN_W       = 16;
   localparam int CUR_W        = 32;
   localparam int ACC_W        = 56;
   localparam int DIV_CNT_W    = $clog2(LEN_W + 1);
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(65536);
   localparam logic [GAIN_W-1:0] MAX_GAIN = GAIN_W'(32768);
   localparam logic [3:0]        CMD_LAST = 4'd8;

   typedef enum logic [3:0] {
      OP_LOAD   = 4'd0,
      OP_CLIP   = 4'd1,
      OP_PLAY   = 4'd2,
      OP_PAUSE  = 4'd3,
      OP_RESUME = 4'd4,
      OP_STOP   = 4'd5,
      OP_GAIN   = 4'd6,
      OP_LOOP   = 4'd7,
      OP_RENDER = 4'd8,
      OP_NONE   = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_PLAYING = 2'd0,
      ST_PAUSED  = 2'd1,
      ST_STOPPED = 2'd2
   } status_type;

   // Decoded command as it travels from the front end to the back end.
   typedef struct packed {
      op_type              op;
      logic [VOICE_W-1:0]  voice;
      logic [ADDR_W-1:0]   address;
      logic [SMP_W-1:0]    sample_value;
      logic [LEN_W-1:0]    length;
      logic                stereo;
      logic [RATE_W-1:0]   rate;
      logic [GAIN_W-1:0]   gain;
      logic                gain_ok;
      logic                loop_en;
   } cmd_type;

   // One voice record as held in the voice memory.
   typedef struct packed {
      logic [CUR_W-1:0]    cursor;
      logic [GAIN_W-1:0]   gain;
      logic                loop_en;
      logic [ADDR_W-1:0]   base;
      logic [LEN_W-1:0]    length;
      logic                stereo;
      logic [RATE_W-1:0]   rate;
      status_type          status;
   } voice_type;

   localparam voice_type RESET_VOICE = '{
      cursor:  '0,
      gain:    '0,
      loop_en: 1'b0,
      base:    '0,
      length:  LEN_W'(1),
      stereo:  1'b0,
      rate:    '0,
      status:  ST_STOPPED
   };

endpackage

### sv/svm_req_if.sv
// Command channel of the sample voice mixer: valid, ready and the command fields.
// Depends on nothing.
interface svm_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         command;
   logic [5:0]         voice_index;
   logic [15:0]        address;
   logic signed [15:0] sample_value;
   logic [16:0]        clip_length;
   logic               stereo;
   logic [23:0]        rate_step;
   logic [15:0]        gain;
   logic               loop_enable;

   modport source (output valid, command, voice_index, address, sample_value,
                   clip_length, stereo, rate_step, gain, loop_enable,
                   input ready);
   modport sink (input valid, command, voice_index, address, sample_value,
                 clip_length, stereo, rate_step, gain, loop_enable,
                 output ready);
endinterface

### sv/svm_rsp_if.sv
// Result channel of the sample voice mixer: valid, ready and the result fields.
// Depends on nothing.
interface svm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_out;
   logic signed [15:0] right_out;
   logic               error;
   logic [1:0]         voice_state;

   modport source (output valid, left_out, right_out, error, voice_state,
                   input ready);
   modport sink (input valid, left_out, right_out, error, voice_state,
                 output ready);
endinterface

### sv/sample_voice_mixer.sv
// Top level of the sample voice mixer: front end, command queue and back end.
// Depends on svm_pkg, svm_req_if, svm_rsp_if, svm_front, svm_queue and svm_back.
//
// The mixer takes one command per beat on the request channel and answers every
// command with exactly one result beat, in order. Commands load a word into the
// 64K-word sample memory, set up a voice's clip, play, pause, resume or stop a
// voice, set its gain or loop flag, or render one stereo frame. A front end
// decodes and clamps each command into a two-entry queue, so the request side
// keeps taking commands until the queue is full, also while the back end is busy
// or a result waits to be taken. The back end handles one command at a time. A
// non-render command passes from the queue through a voice-memory read and an
// execute state to the result register. A render walks all 64 voices through the
// voice memory: a voice without a clip is only read; a configured voice is read
// and checked; a playing voice then runs the sample reads, three multiply steps
// and the accumulate once per output channel computed (one pass for a mono clip,
// two for stereo), then advances and stores its cursor, a looping voice waiting
// on the bit-serial remainder unit for its cursor wrap. A final rounding step
// closes the render. The sample memory has one read port, so each output channel
// of a voice reads its two neighbouring frames one after the other. After reset
// all voices are stopped and unconfigured; sample words that were never loaded
// read back as arbitrary values.
module sample_voice_mixer (
   input logic       clock,
   input logic       reset,
   svm_req_if.sink   req_ch,
   svm_rsp_if.source rsp_ch
);
   import svm_pkg::*;

   cmd_type push_item;
   logic    push;
   logic    full;
   logic    pop;
   logic    q_valid;
   cmd_type q_item;

   // Decode each request beat; the queue's fill level sets ready.
   svm_front u_front (
      .req       (req_ch),
      .push_item (push_item),
      .push      (push),
      .full      (full)
   );

   svm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   // Execution, render sequencing and the result register.
   svm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_item  (q_item),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

endmodule

### sv/svm_front.sv
// Front end: takes command beats and classifies them into decoded commands.
// Depends on svm_pkg and svm_req_if.
module svm_front (
   svm_req_if.sink          req,
   output svm_pkg::cmd_type push_item,
   output logic             push,
   input  logic             full
);
   import svm_pkg::*;

   assign req.ready = !full;
   assign push      = req.valid && !full;

   always_comb begin
      push_item.op = (req.command <= CMD_LAST) ? op_type'(req.command) : OP_NONE;
      push_item.voice        = req.voice_index;
      push_item.address      = req.address;
      push_item.sample_value = req.sample_value;
      // A zero length counts as one frame; lengths above MAX_LEN saturate to it.
      if (req.clip_length == '0) begin
         push_item.length = LEN_W'(1);
      end else if (req.clip_length > MAX_LEN) begin
         push_item.length = MAX_LEN;
      end else begin
         push_item.length = req.clip_length;
      end
      push_item.stereo  = req.stereo;
      push_item.rate    = req.rate_step;
      push_item.gain    = req.gain;
      push_item.gain_ok = (req.gain <= MAX_GAIN);
      push_item.loop_en = req.loop_enable;
   end

endmodule

### sv/svm_queue.sv
// Short queue of decoded commands between the front end and the back end.
// Depends on svm_pkg.
module svm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  svm_pkg::cmd_type push_item,
   output logic             full,
   input  logic             pop,
   output logic             q_valid,
   output svm_pkg::cmd_type q_item
);
   import svm_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### sv/svm_mod.sv
// Bit-serial remainder unit: one restoring step per cycle over the dividend bits.
// Depends on svm_pkg.
module svm_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [svm_pkg::LEN_W-1:0] dividend,
   input  logic [svm_pkg::LEN_W-1:0] divisor,
   output logic                      done,
   output logic [svm_pkg::LEN_W-1:0] remainder
);
   import svm_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [LEN_W-1:0]     quo_ff;
   logic [LEN_W-1:0]     rem_ff;
   logic [LEN_W:0]       trial;
   logic [LEN_W:0]       diff;
   logic [LEN_W-1:0]     rem_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[LEN_W-1]};
      diff   = trial - {1'b0, divisor};
      rem_in = (trial >= {1'b0, divisor}) ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(LEN_W);
            quo_ff  <= dividend;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[LEN_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

### sv/svm_back.sv
// Back end: voice and sample memories, command execution, the render sequencer
// and the result register. Depends on svm_pkg, svm_rsp_if and svm_mod.
module svm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  svm_pkg::cmd_type q_item,
   output logic             pop,
   svm_rsp_if.source        rsp
);
   import svm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_R_READ, S_R_CHECK, S_RA, S_RB, S_MUL1, S_MUL2, S_MUL3,
      S_ACC, S_ADV, S_MOD, S_WRBACK, S_FIN, S_RD, S_EXEC
   } state_type;

   state_type                state_ff;
   cmd_type                  cmd_ff;
   logic [VOICE_W-1:0]       vi_ff;
   voice_type                rec_ff;
   logic [15:0]              first_ff;
   logic [15:0]              second_ff;
   logic                     ch_ff;
   logic signed [15:0]       a_ff;
   logic signed [16:0]       d_ff;
   logic signed [32:0]       s_ff;
   logic signed [48:0]       p_ff;
   logic signed [ACC_W-1:0]  acc_l_ff;
   logic signed [ACC_W-1:0]  acc_r_ff;
   logic [15:0]              lo_ff;
   logic [15:0]              left_ff;
   logic [15:0]              right_ff;
   logic [VOICES-1:0]        cfg_ff;
   logic                     rsp_valid_ff;
   logic [15:0]              rsp_left_ff;
   logic [15:0]              rsp_right_ff;
   logic                     rsp_error_ff;
   logic [1:0]               rsp_state_ff;

   voice_type                rec_mem [VOICES];
   voice_type                rec_rd_ff;
   logic [SMP_W-1:0]         smp_mem [SAMPLE_WORDS];
   logic [SMP_W-1:0]         smp_rd_ff;

   logic                     rec_rd_en;
   logic [VOICE_W-1:0]       rec_rd_addr;
   logic                     rec_wr_en;
   logic [VOICE_W-1:0]       rec_wr_addr;
   voice_type                rec_wr_data;
   logic                     smp_rd_en;
   logic [ADDR_W-1:0]        smp_rd_addr;
   logic                     smp_wr_en;

   logic                     out_free;
   logic                     go;
   voice_type                cur;
   voice_type                upd;
   logic                     exec_wr;
   logic                     exec_err;

   logic [LEN_W-1:0]         len_m1;
   logic [LEN_W-1:0]         cur_hi;
   logic [LEN_W-1:0]         first17;
   logic [LEN_W-1:0]         first_nx;
   logic [15:0]              chk_second;

   logic signed [33:0]       df_prod;
   logic signed [33:0]       a_sh;
   logic signed [33:0]       s_sum;
   logic signed [49:0]       gp;
   logic signed [ACC_W-1:0]  p_ext;
   logic signed [16:0]       d_in;
   logic [CUR_W:0]           nxt;
   logic [CUR_W:0]           end_pos;
   logic                     last_voice;

   logic                     mod_start;
   logic                     mod_done;
   logic [LEN_W-1:0]         mod_rem;

   // Rounds a Q10.46 sum to Q1.15 with ties upward and saturates it.
   function automatic logic [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W:0]    t;
      logic signed [ACC_W-31:0] q;
      t = {acc[ACC_W-1], acc} + (ACC_W+1)'(64'd1 << 30);
      q = t[ACC_W:31];
      if (q > (ACC_W-30)'(32767)) begin
         return 16'h7fff;
      end else if (q < -$signed((ACC_W-30)'(32768))) begin
         return 16'h8000;
      end else begin
         return q[15:0];
      end
   endfunction

   svm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (nxt[CUR_W:16]),
      .divisor   (rec_ff.length),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Memories.
   always_ff @(posedge clock) begin
      if (rec_wr_en) begin
         rec_mem[rec_wr_addr] <= rec_wr_data;
      end
      if (rec_rd_en) begin
         rec_rd_ff <= rec_mem[rec_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (smp_wr_en) begin
         smp_mem[cmd_ff.address] <= cmd_ff.sample_value;
      end
      if (smp_rd_en) begin
         smp_rd_ff <= smp_mem[smp_rd_addr];
      end
   end

   // Render datapath.
   always_comb begin
      len_m1     = rec_rd_ff.length - 1'b1;
      cur_hi     = {1'b0, rec_rd_ff.cursor[CUR_W-1:16]};
      first17    = (cur_hi >= len_m1) ? len_m1 : cur_hi;
      first_nx   = first17 + 1'b1;
      if (first_nx < rec_rd_ff.length) begin
         chk_second = first_nx[15:0];
      end else begin
         chk_second = rec_rd_ff.loop_en ? 16'd0 : first17[15:0];
      end

      d_in    = $signed({smp_rd_ff[15], smp_rd_ff}) - $signed({a_ff[15], a_ff});
      df_prod = d_ff * $signed({1'b0, rec_ff.cursor[15:0]});
      a_sh    = {{2{a_ff[15]}}, a_ff, 16'd0};
      s_sum   = a_sh + df_prod;
      gp      = s_ff * $signed({1'b0, rec_ff.gain});
      p_ext   = {{(ACC_W-49){p_ff[48]}}, p_ff};

      nxt     = {1'b0, rec_ff.cursor} + (CUR_W+1)'(rec_ff.rate);
      end_pos = {rec_ff.length, 16'd0};
      last_voice = (vi_ff == VOICE_W'(VOICES - 1));
   end

   // Command execution on the addressed voice.
   always_comb begin
      cur      = cfg_ff[cmd_ff.voice] ? rec_rd_ff : RESET_VOICE;
      upd      = cur;
      exec_wr  = 1'b0;
      exec_err = 1'b0;
      unique case (cmd_ff.op)
         OP_CLIP: begin
            upd.base   = cmd_ff.address;
            upd.length = cmd_ff.length;
            upd.stereo = cmd_ff.stereo;
            upd.rate   = cmd_ff.rate;
            upd.status = ST_STOPPED;
            upd.cursor = '0;
            exec_wr    = 1'b1;
         end
         OP_PLAY, OP_PAUSE, OP_RESUME, OP_STOP, OP_GAIN, OP_LOOP: begin
            if (!cfg_ff[cmd_ff.voice]) begin
               exec_err = 1'b1;
            end else begin
               exec_wr = 1'b1;
               unique case (cmd_ff.op)
                  OP_PLAY: begin
                     upd.status = ST_PLAYING;
                     upd.cursor = '0;
                  end
                  OP_PAUSE: begin
                     if (cur.status == ST_PLAYING) upd.status = ST_PAUSED;
                  end
                  OP_RESUME: begin
                     if (cur.status == ST_PAUSED) upd.status = ST_PLAYING;
                  end
                  OP_STOP: begin
                     upd.status = ST_STOPPED;
                     upd.cursor = '0;
                  end
                  OP_GAIN: begin
                     if (cmd_ff.gain_ok) upd.gain = cmd_ff.gain;
                  end
                  default: begin
                     upd.loop_en = cmd_ff.loop_en;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Memory port control.
   always_comb begin
      out_free    = !rsp_valid_ff || rsp.ready;
      go          = (state_ff == S_EXEC) && out_free;
      pop         = (state_ff == S_IDLE) && q_valid;
      rec_rd_en   = ((state_ff == S_R_READ) && cfg_ff[vi_ff]) || (state_ff == S_RD);
      rec_rd_addr = (state_ff == S_RD) ? cmd_ff.voice : vi_ff;
      rec_wr_en   = (state_ff == S_WRBACK) || (go && exec_wr);
      rec_wr_addr = (state_ff == S_WRBACK) ? vi_ff : cmd_ff.voice;
      rec_wr_data = (state_ff == S_WRBACK) ? rec_ff : upd;
      smp_wr_en   = go && (cmd_ff.op == OP_LOAD);
      smp_rd_en   = (state_ff == S_RA) || (state_ff == S_RB);
      if (state_ff == S_RA) begin
         smp_rd_addr = rec_ff.base + (rec_ff.stereo ? {first_ff[14:0], ch_ff} : first_ff);
      end else begin
         smp_rd_addr = rec_ff.base + (rec_ff.stereo ? {second_ff[14:0], ch_ff} : second_ff);
      end
      mod_start   = (state_ff == S_ADV) && rec_ff.loop_en;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.left_out    = rsp_left_ff;
   assign rsp.right_out   = rsp_right_ff;
   assign rsp.error       = rsp_error_ff;
   assign rsp.voice_state = rsp_state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cmd_ff <= q_item;
                  if (q_item.op == OP_RENDER) begin
                     vi_ff    <= '0;
                     acc_l_ff <= '0;
                     acc_r_ff <= '0;
                     state_ff <= S_R_READ;
                  end else begin
                     state_ff <= S_RD;
                  end
               end
            end
            S_R_READ: begin
               if (cfg_ff[vi_ff]) begin
                  state_ff <= S_R_CHECK;
               end else if (last_voice) begin
                  state_ff <= S_FIN;
               end else begin
                  vi_ff <= vi_ff + 1'b1;
               end
            end
            S_R_CHECK: begin
               if (rec_rd_ff.status == ST_PLAYING) begin
                  rec_ff    <= rec_rd_ff;
                  first_ff  <= first17[15:0];
                  second_ff <= chk_second;
                  ch_ff     <= 1'b0;
                  state_ff  <= S_RA;
               end else if (last_voice) begin
                  state_ff <= S_FIN;
               end else begin
                  vi_ff    <= vi_ff + 1'b1;
                  state_ff <= S_R_READ;
               end
            end
            S_RA: begin
               state_ff <= S_RB;
            end
            S_RB: begin
               a_ff     <= smp_rd_ff;
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               d_ff     <= d_in;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               s_ff     <= s_sum[32:0];
               state_ff <= S_MUL3;
            end
            S_MUL3: begin
               p_ff     <= gp[48:0];
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (!rec_ff.stereo) begin
                  acc_l_ff <= acc_l_ff + p_ext;
                  acc_r_ff <= acc_r_ff + p_ext;
                  state_ff <= S_ADV;
               end else if (!ch_ff) begin
                  acc_l_ff <= acc_l_ff + p_ext;
                  ch_ff    <= 1'b1;
                  state_ff <= S_RA;
               end else begin
                  acc_r_ff <= acc_r_ff + p_ext;
                  state_ff <= S_ADV;
               end
            end
            S_ADV: begin
               if (rec_ff.loop_en) begin
                  lo_ff    <= nxt[15:0];
                  state_ff <= S_MOD;
               end else if (nxt >= end_pos) begin
                  rec_ff.status <= ST_STOPPED;
                  rec_ff.cursor <= '0;
                  state_ff      <= S_WRBACK;
               end else begin
                  rec_ff.cursor <= nxt[CUR_W-1:0];
                  state_ff      <= S_WRBACK;
               end
            end
            S_MOD: begin
               if (mod_done) begin
                  rec_ff.cursor <= {mod_rem[15:0], lo_ff};
                  state_ff      <= S_WRBACK;
               end
            end
            S_WRBACK: begin
               if (last_voice) begin
                  state_ff <= S_FIN;
               end else begin
                  vi_ff    <= vi_ff + 1'b1;
                  state_ff <= S_R_READ;
               end
            end
            S_FIN: begin
               left_ff  <= round_sat(acc_l_ff);
               right_ff <= round_sat(acc_r_ff);
               state_ff <= S_RD;
            end
            S_RD: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (out_free) begin
                  if (cmd_ff.op == OP_CLIP) begin
                     cfg_ff[cmd_ff.voice] <= 1'b1;
                  end
                  rsp_left_ff  <= (cmd_ff.op == OP_RENDER) ? left_ff : 16'd0;
                  rsp_right_ff <= (cmd_ff.op == OP_RENDER) ? right_ff : 16'd0;
                  rsp_error_ff <= exec_err;
                  rsp_state_ff <= upd.status;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

### tb/svm_checker.sv
// Checker for the sample voice mixer: watches both channels, predicts each result beat.
// Depends on svm_pkg, svm_req_if and svm_rsp_if.
`timescale 1ns / 1ps

module svm_checker (
   input  logic clock,
   input  logic reset,
   svm_req_if   req_mon,
   svm_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending
);
   import svm_pkg::*;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               error;
      logic [1:0]         state;
   } mix_result_type;

   mix_result_type expected_q[$];
   logic [15:0] sample_mem [0:SAMPLE_WORDS-1];
   status_type  v_status [VOICES];
   logic        v_configured [VOICES];
   logic [31:0] v_cursor [VOICES];
   logic [15:0] v_gain [VOICES];
   logic        v_loop [VOICES];
   logic [15:0] v_base [VOICES];
   logic [16:0] v_length [VOICES];
   logic        v_stereo [VOICES];
   logic [23:0] v_rate [VOICES];

   // Rounds the exact Q18.46 sum to Q1.15, ties upwards, and saturates.
   function automatic logic signed [15:0] round_sat(input longint acc);
      longint q;
      q = (acc + (longint'(1) << 30)) >>> 31;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return 16'(q);
   endfunction

   function automatic void mix_one(input int v, input longint pos, inout longint acc_l,
                                   inout longint acc_r);
      longint len, chans, first, second, frac, ua, ub, w, s;
      logic [15:0] ia, ib;
      len = v_length[v];
      chans = v_stereo[v] ? 2 : 1;
      first = pos >> 16;
      frac = pos & 'hFFFF;
      if (first >= len) first = len - 1;
      if (first + 1 < len) second = first + 1;
      else second = v_loop[v] ? 0 : first;
      for (int ch = 0; ch < 2; ch++) begin
         ia = 16'(v_base[v] + first * chans + (v_stereo[v] ? ch : 0));
         ib = 16'(v_base[v] + second * chans + (v_stereo[v] ? ch : 0));
         ua = longint'(sample_mem[ia] ^ 16'h8000);
         ub = longint'(sample_mem[ib] ^ 16'h8000);
         w = ua * (65536 - frac) + ub * frac;
         s = (w - (longint'(32768) << 16)) * longint'(v_gain[v]);
         if (ch == 0) acc_l += s;
         else acc_r += s;
      end
   endfunction

   function automatic void render_frame(output logic signed [15:0] l,
                                        output logic signed [15:0] r);
      longint acc_l, acc_r, clip_end, pos, nxt;
      acc_l = 0;
      acc_r = 0;
      for (int v = 0; v < VOICES; v++) begin
         if (v_status[v] == ST_PLAYING) begin
            clip_end = longint'(v_length[v]) << 16;
            pos = v_cursor[v];
            if (v_loop[v]) pos = pos % clip_end;
            if (v_loop[v] || pos < clip_end) mix_one(v, pos, acc_l, acc_r);
            nxt = longint'(v_cursor[v]) + v_rate[v];
            if (v_loop[v]) begin
               v_cursor[v] = 32'(nxt % clip_end);
            end else if (nxt >= clip_end) begin
               v_status[v] = ST_STOPPED;
               v_cursor[v] = '0;
            end else begin
               v_cursor[v] = 32'(nxt);
            end
         end
      end
      l = round_sat(acc_l);
      r = round_sat(acc_r);
   endfunction

   function automatic mix_result_type predict_beat(input logic [3:0] cmd, input logic [5:0] v,
      input logic [15:0] addr, input logic [15:0] word, input logic [16:0] len_in,
      input logic st, input logic [23:0] rate, input logic [15:0] g, input logic lp);
      mix_result_type res;
      logic [16:0] len;
      res = '{left: '0, right: '0, error: 1'b0, state: '0};
      if (cmd == OP_LOAD) begin
         sample_mem[addr] = word;
      end else if (cmd == OP_CLIP) begin
         len = (len_in == 0) ? 17'd1 : (len_in > MAX_LEN ? MAX_LEN : len_in);
         v_base[v] = addr;
         v_length[v] = len;
         v_stereo[v] = st;
         v_rate[v] = rate;
         v_configured[v] = 1'b1;
         v_status[v] = ST_STOPPED;
         v_cursor[v] = '0;
      end else if (cmd >= OP_PLAY && cmd <= OP_LOOP) begin
         if (!v_configured[v]) begin
            res.error = 1'b1;
         end else begin
            case (cmd)
               OP_PLAY: begin
                  v_status[v] = ST_PLAYING;
                  v_cursor[v] = '0;
               end
               OP_PAUSE: if (v_status[v] == ST_PLAYING) v_status[v] = ST_PAUSED;
               OP_RESUME: if (v_status[v] == ST_PAUSED) v_status[v] = ST_PLAYING;
               OP_STOP: begin
                  v_status[v] = ST_STOPPED;
                  v_cursor[v] = '0;
               end
               OP_GAIN: if (g <= MAX_GAIN) v_gain[v] = g;
               default: v_loop[v] = lp;
            endcase
         end
      end else if (cmd == OP_RENDER) begin
         render_frame(res.left, res.right);
      end
      res.state = v_status[v];
      return res;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      mix_result_type got, want;
      if (reset) begin
         expected_q.delete();
         fail_count <= 0;
         for (int v = 0; v < VOICES; v++) begin
            v_status[v] = ST_STOPPED;
            v_configured[v] = 1'b0;
            v_cursor[v] = '0;
            v_gain[v] = '0;
            v_loop[v] = 1'b0;
            v_base[v] = '0;
            v_length[v] = 17'd1;
            v_stereo[v] = 1'b0;
            v_rate[v] = '0;
         end
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(predict_beat(req_mon.command, req_mon.voice_index,
               req_mon.address, req_mon.sample_value, req_mon.clip_length,
               req_mon.stereo, req_mon.rate_step, req_mon.gain, req_mon.loop_enable));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{left: rsp_mon.left_out, right: rsp_mon.right_out,
                    error: rsp_mon.error, state: rsp_mon.voice_state};
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result beat: l=%0d r=%0d err=%0b st=%0d",
                           got.left, got.right, got.error, got.state);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (got.left !== want.left || got.right !== want.right ||
                   got.error !== want.error || got.state !== want.state) begin
                  if (fail_count < 10)
                     $display("mismatch: expected l=%0d r=%0d err=%0b st=%0d, got l=%0d r=%0d err=%0b st=%0d",
                              want.left, want.right, want.error, want.state,
                              got.left, got.right, got.error, got.state);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### tb/tb_sample_voice_mixer.sv
// Top of the sample voice mixer testbench: clock, reset, command stimulus and verdict.
// Depends on svm_pkg, both channel interfaces, sample_voice_mixer and svm_checker.
`timescale 1ns / 1ps

module tb_sample_voice_mixer;
   import svm_pkg::*;

   // Clips in the random part only ever reach words inside this window, which is
   // loaded in full before anything plays, so no never-written word is ever read.
   localparam int WINDOW = 256;

   logic clock;
   logic reset;
   logic quiet;      // set during the stretch in which neither side idles
   int   fail_count;
   int   pending;

   svm_req_if req_ch ();
   svm_rsp_if rsp_ch ();

   sample_voice_mixer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   svm_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // The result side stalls at random, about a quarter of the time, except in the
   // quiet stretch.
   always @(posedge clock) begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 26);
   end

   // Drives one command beat and holds it until the mixer takes it. Idle cycles
   // are inserted in front of the beat at random.
   task automatic send_beat(input logic [3:0] cmd, input logic [5:0] v, input logic [15:0] addr,
      input logic [15:0] word, input logic [16:0] len, input logic st, input logic [23:0] rate,
      input logic [15:0] g, input logic lp);
      while (!quiet && $urandom_range(99) < 26) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= cmd;
      req_ch.voice_index <= v;
      req_ch.address     <= addr;
      req_ch.sample_value <= word;
      req_ch.clip_length <= len;
      req_ch.stereo      <= st;
      req_ch.rate_step   <= rate;
      req_ch.gain        <= g;
      req_ch.loop_enable <= lp;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Voice command with random content in the fields that it does not use.
   task automatic voice_beat(input logic [3:0] cmd, input logic [5:0] v, input logic [15:0] g,
                             input logic lp);
      send_beat(cmd, v, 16'($urandom), 16'($urandom), 17'($urandom), 1'($urandom),
                24'($urandom), g, lp);
   endtask

   // One random beat. Clips are kept inside the loaded window whatever their
   // cursor does, since the first frame read is clamped to the clip.
   task automatic random_beat();
      logic [3:0]  cmd;
      logic [5:0]  v;
      logic [15:0] addr;
      logic [16:0] len;
      logic        st;
      logic [23:0] rate;
      logic [15:0] g;
      int          pick;
      int          span;
      pick = $urandom_range(99);
      v = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      addr = 16'($urandom);
      len = 17'($urandom);
      st = 1'($urandom);
      rate = 24'($urandom);
      g = 16'($urandom);
      if (pick < 15) begin
         cmd = OP_LOAD;
         if ($urandom_range(3) != 0) addr = 16'($urandom_range(WINDOW - 1));
      end else if (pick < 25) begin
         cmd = OP_CLIP;
         len = 17'(1 + (($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(15)));
         span = int'(len) * (st ? 2 : 1);
         addr = 16'($urandom_range(WINDOW - span));
         if ($urandom_range(19) == 0) len = 17'd0;
         case ($urandom_range(3))
            0: rate = 24'($urandom_range(24'hFFFFFF));
            1: rate = 24'd0;
            default: rate = 24'($urandom_range(24'h30000));
         endcase
      end else if (pick < 37) cmd = OP_PLAY;
      else if (pick < 43) cmd = OP_PAUSE;
      else if (pick < 49) cmd = OP_RESUME;
      else if (pick < 53) cmd = OP_STOP;
      else if (pick < 63) begin
         cmd = OP_GAIN;
         if ($urandom_range(9) != 0) g = 16'($urandom_range(32768));
      end else if (pick < 69) cmd = OP_LOOP;
      else if (pick < 97) cmd = OP_RENDER;
      else cmd = 4'($urandom_range(15, 9));
      send_beat(cmd, v, addr, 16'($urandom), len, st, rate, g, 1'($urandom));
   endtask

   initial begin
      reset <= 1'b1;
      quiet <= 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.command     <= OP_LOAD;
      req_ch.voice_index <= '0;
      req_ch.address     <= '0;
      req_ch.sample_value <= '0;
      req_ch.clip_length <= '0;
      req_ch.stereo      <= 1'b0;
      req_ch.rate_step   <= '0;
      req_ch.gain        <= '0;
      req_ch.loop_enable <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the window with random words, then the two top words of memory
      // with the extremes of the sample range.
      for (int a = 0; a < WINDOW; a++)
         send_beat(OP_LOAD, 6'($urandom), 16'(a), 16'($urandom), 17'($urandom),
                   1'($urandom), 24'($urandom), 16'($urandom), 1'($urandom));
      send_beat(OP_LOAD, 6'd0, 16'hFFFF, 16'h7FFF, '0, 1'b0, '0, '0, 1'b0);
      send_beat(OP_LOAD, 6'd0, 16'hFFFE, 16'h8000, '0, 1'b0, '0, '0, 1'b0);

      // Directed part. A command on a voice that has no clip reports an error.
      voice_beat(OP_PLAY, 6'd5, '0, 1'b0);
      // A clip of length zero becomes one frame, at the very top of memory.
      send_beat(OP_CLIP, 6'd0, 16'hFFFF, '0, 17'd0, 1'b0, 24'd0, '0, 1'b0);
      voice_beat(OP_GAIN, 6'd0, MAX_GAIN, 1'b0);
      voice_beat(OP_PLAY, 6'd0, '0, 1'b0);
      voice_beat(OP_RENDER, 6'd0, '0, 1'b0);
      // An oversized stereo clip saturates to the longest length and wraps
      // round the end of memory; it is rendered once only and then stopped.
      send_beat(OP_CLIP, 6'd63, 16'hFFFE, '0, 17'h1FFFF, 1'b1, 24'hFFFFFF, '0, 1'b0);
      voice_beat(OP_GAIN, 6'd63, 16'hFFFF, 1'b0);
      voice_beat(OP_GAIN, 6'd63, MAX_GAIN, 1'b0);
      voice_beat(OP_LOOP, 6'd63, '0, 1'b1);
      voice_beat(OP_PLAY, 6'd63, '0, 1'b0);
      voice_beat(OP_RENDER, 6'd63, '0, 1'b0);
      voice_beat(OP_STOP, 6'd63, '0, 1'b0);
      // Pause and resume, each also where it has no effect.
      voice_beat(OP_PAUSE, 6'd0, '0, 1'b0);
      voice_beat(OP_PAUSE, 6'd0, '0, 1'b0);
      voice_beat(OP_RENDER, 6'd0, '0, 1'b0);
      voice_beat(OP_RESUME, 6'd0, '0, 1'b0);
      voice_beat(OP_RESUME, 6'd0, '0, 1'b0);
      voice_beat(OP_RENDER, 6'd0, '0, 1'b0);
      voice_beat(OP_STOP, 6'd0, '0, 1'b0);
      voice_beat(4'd15, 6'd0, '0, 1'b0);
      // Park both voices on clips inside the window before the random part.
      send_beat(OP_CLIP, 6'd0, 16'd0, '0, 17'd4, 1'b0, 24'h8000, '0, 1'b0);
      send_beat(OP_CLIP, 6'd63, 16'd8, '0, 17'd2, 1'b1, 24'h4000, '0, 1'b0);

      for (int i = 0; i < 1170; i++) begin
         quiet <= (i >= 500 && i < 700);
         random_beat();
      end
      req_ch.valid <= 1'b0;
      quiet <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Generous bound: every render at its worst case, several times over.
   initial begin
      #200_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

### sim.f
sv/svm_pkg.sv
sv/svm_req_if.sv
sv/svm_rsp_if.sv
sv/svm_front.sv
sv/svm_queue.sv
sv/svm_mod.sv
sv/svm_back.sv
sv/sample_voice_mixer.sv
tb/svm_checker.sv
tb/tb_sample_voice_mixer.sv
